[rtl/rtdc_pkg.sv]
`timescale 1ns / 1ps
package rtdc_pkg;

	localparam int ADC_BITS_DEF   = 24;
	localparam int NEWTON_ITER_DEF = 50;

	localparam int CODE_W  = 24;
	localparam int TEMP_W  = 21;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 2;
	localparam int MUL_STEPS = 32;
	localparam int DIV_STEPS = 64;
	localparam int CNT_W   = 7;
	localparam int DEN_W   = 40;
	localparam int R_W     = 28;

	localparam logic [CIDX_W-1:0] CFG_SENSOR = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_REF    = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_GAIN   = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_DOUBLE = 2'd3;

	localparam logic signed [63:0] CA_Q43  = 64'sd34377770359;
	localparam logic signed [63:0] CB_Q54  = -64'sd10403315139;
	localparam logic signed [63:0] CB2_Q52 = -64'sd5201657570;
	localparam logic signed [63:0] CC_Q64  = -64'sd77162730;
	localparam logic signed [63:0] CC_Q62  = -64'sd19290683;
	localparam logic signed [63:0] ONE_Q32 = 64'sd4294967296;
	localparam logic signed [63:0] T_MIN   = -64'sd16777216;
	localparam logic signed [63:0] T_MAX   = 64'sd67108864;
	localparam logic signed [63:0] STEP_DONE = 64'sd65;
	localparam logic signed [63:0] OUT_MIN = -64'sd204800;
	localparam logic signed [63:0] OUT_MAX = 64'sd870400;

	localparam logic [63:0] SPAN_LO [2] = '{64'd1213727, 64'd12137268};
	localparam logic [63:0] SPAN_HI [2] = '{64'd25590562, 64'd255905628};
	localparam logic [63:0] R0_Q16  [2] = '{64'd6553600, 64'd65536000};
	localparam logic [31:0] R0      [2] = '{32'd100, 32'd1000};
	localparam logic [DEN_W-1:0] CA_R0 [2] = '{40'd1678602100, 40'd16786021000};

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHK, ST_RMUL, ST_RDIV, ST_T0,
		ST_H1, ST_H2, ST_H3, ST_HS,
		ST_G1, ST_G2, ST_G3, ST_GP, ST_GR,
		ST_ND, ST_FIN, ST_DONE
	} rtdc_state_t;

	function automatic logic signed [31:0] clamp_t(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = v;
		if (v < T_MIN) c = T_MIN;
		if (v > T_MAX) c = T_MAX;
		return c[31:0];
	endfunction

endpackage

[rtl/rtd_code_to_temperature.sv]
`timescale 1ns / 1ps
// channel   signals                                  word
// input     in_valid / in_ready                      adc_code
// output    out_valid / out_ready                    temperature, in_range
// config    cfg_we, cfg_index, cfg_wdata             one register per write
//
// One word at a time through a shared bit-serial multiplier and a radix-2 divider.
// Setup: one product (ST_RMUL) and two quotients (ST_RDIV, ST_T0) from accept to the
// first step; each Newton step 9 products and one quotient below 0 C, 7 products and
// one quotient above; up to NEWTON_ITERATIONS steps, then through ST_FIN and ST_DONE
// to the output register.
// in_ready is high in idle, also while a finished word waits on out_ready.
// arst_n clears control and configuration to their reset values.
module rtd_code_to_temperature #(
	parameter int ADC_BITS = rtdc_pkg::ADC_BITS_DEF,
	parameter int NEWTON_ITERATIONS = rtdc_pkg::NEWTON_ITER_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rtdc_pkg::CODE_W-1:0]  adc_code,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [rtdc_pkg::TEMP_W-1:0] temperature,
	output logic                         in_range,
	input  logic                         cfg_we,
	input  logic [rtdc_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [rtdc_pkg::CFG_W-1:0]   cfg_wdata
);
	import rtdc_pkg::*;

	localparam int ITER_W = $clog2(NEWTON_ITERATIONS + 1);
	localparam logic [63:0] MID = 64'd1 << (ADC_BITS - 1);

	rtdc_state_t state_q, state_d;

	logic        sel_q, dbl_q;
	logic [15:0] ref_q;
	logic [7:0]  gain_q;

	logic [ADC_BITS-1:0]    code_q;
	logic [R_W-1:0]         r_q;
	logic                   cold_q, neg_q;
	logic signed [31:0]     t_q;
	logic signed [63:0]     g_q, slope_q;
	logic [ITER_W-1:0]      iter_q;
	logic [CNT_W-1:0]       cnt_q;
	logic signed [TEMP_W-1:0] res_t_q;
	logic                   res_ok_q;
	logic                   out_valid_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic                   in_range_q;

	logic signed [63:0] mul_acc_q, mul_a_q;
	logic [31:0]        mul_b_q;
	logic [63:0]        quo_q;
	logic [DEN_W-1:0]   rem_q, den_q;

	logic               is_mul, is_div, skip, unit_done;
	logic signed [63:0] op_a;
	logic [31:0]        op_b;
	logic [63:0]        op_num;
	logic [DEN_W-1:0]   op_den;
	logic               op_neg;

	logic signed [63:0] mul_term, prod;
	logic [DEN_W:0]     rem_sh;
	logic               ge;
	logic [DEN_W-1:0]   rem_nx;
	logic [63:0]        quo_nx;
	logic signed [63:0] q_s;
	logic [81:0]        rnum_w;
	logic               span_ok;
	logic signed [63:0] diff, slope_v, nt, dstep, tr;
	logic               stop;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign temperature = temp_q;
	assign in_range    = in_range_q;

	// datapath arithmetic
	assign mul_term = mul_b_q[0] ? mul_a_q : 64'sd0;
	assign prod = (cnt_q == CNT_W'(MUL_STEPS)) ? (mul_acc_q - mul_term)
		: (mul_acc_q + mul_term);
	assign rem_sh = {rem_q, quo_q[63]};
	assign ge = (rem_sh >= {1'b0, den_q});
	assign rem_nx = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
	assign quo_nx = {quo_q[62:0], ge};
	assign q_s = neg_q ? -$signed(quo_nx) : $signed(quo_nx);
	assign rnum_w = {prod, 18'd0} >> (ADC_BITS + (dbl_q ? 0 : 1));
	assign span_ok = (quo_nx >= SPAN_LO[sel_q]) && (quo_nx <= SPAN_HI[sel_q]);
	assign diff = $signed({36'd0, r_q}) - $signed(R0_Q16[sel_q]);
	assign slope_v = prod >>> 19;
	assign nt = 64'(clamp_t(64'(t_q) + q_s));
	assign dstep = nt - 64'(t_q);
	assign stop = ((dstep <= STEP_DONE) && (dstep >= -STEP_DONE))
		|| (iter_q == ITER_W'(NEWTON_ITERATIONS - 1));
	assign tr = (64'(t_q) + 64'sd32) >>> 6;

	// operation select
	always_comb begin
		is_mul = 1'b0;
		is_div = 1'b0;
		skip   = 1'b0;
		op_a   = g_q;
		op_b   = t_q;
		op_num = 64'd0;
		op_den = DEN_W'(1);
		op_neg = 1'b0;
		unique case (state_q)
			ST_RMUL: begin
				is_mul = 1'b1;
				op_a   = $signed(64'(code_q) - MID);
				op_b   = {16'd0, ref_q};
			end
			ST_RDIV: begin
				is_div = 1'b1;
				op_num = g_q;
				op_den = (gain_q == 8'd0) ? DEN_W'(1) : DEN_W'(gain_q);
			end
			ST_T0: begin
				is_div = 1'b1;
				op_num = (diff[63] ? -diff : diff) << 32;
				op_den = CA_R0[sel_q];
				op_neg = diff[63];
			end
			ST_H1: begin
				is_mul = cold_q;
				skip   = !cold_q;
				op_a   = CC_Q62;
				op_b   = (t_q <<< 2) - 32'sd19660800;
			end
			ST_G1: begin
				is_mul = cold_q;
				skip   = !cold_q;
				op_a   = CC_Q64;
				op_b   = t_q - 32'sd6553600;
			end
			ST_H2, ST_H3, ST_G2, ST_G3, ST_GP: begin
				is_mul = 1'b1;
			end
			ST_HS, ST_GR: begin
				is_mul = 1'b1;
				op_b   = R0[sel_q];
			end
			ST_ND: begin
				is_div = 1'b1;
				op_num = (g_q[63] ? -g_q : g_q) << 24;
				op_den = slope_q[DEN_W-1:0];
				op_neg = g_q[63];
			end
			default: ;
		endcase
		unit_done = (is_mul && cnt_q == CNT_W'(MUL_STEPS))
			|| (is_div && cnt_q == CNT_W'(DIV_STEPS));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_CHK;
			ST_CHK:  state_d = (64'(code_q) <= MID) ? ST_DONE : ST_RMUL;
			ST_RMUL: if (unit_done) state_d = ST_RDIV;
			ST_RDIV: if (unit_done) state_d = span_ok ? ST_T0 : ST_DONE;
			ST_T0:   if (unit_done) state_d = ST_H1;
			ST_H1:   if (skip || unit_done) state_d = ST_H2;
			ST_H2:   if (unit_done) state_d = ST_H3;
			ST_H3:   if (unit_done) state_d = ST_HS;
			ST_HS:   if (unit_done) state_d = (slope_v <= 0) ? ST_FIN : ST_G1;
			ST_G1:   if (skip || unit_done) state_d = ST_G2;
			ST_G2:   if (unit_done) state_d = ST_G3;
			ST_G3:   if (unit_done) state_d = ST_GP;
			ST_GP:   if (unit_done) state_d = ST_GR;
			ST_GR:   if (unit_done) state_d = ST_ND;
			ST_ND:   if (unit_done) state_d = stop ? ST_FIN : ST_H1;
			ST_FIN:  state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
			ref_q       <= 16'd1500;
			gain_q      <= 8'd1;
			dbl_q       <= 1'b1;
		end else begin
			state_q <= state_d;
			if (is_mul || is_div)
				cnt_q <= unit_done ? '0 : cnt_q + CNT_W'(1);
			if (state_q == ST_DONE && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SENSOR: sel_q  <= cfg_wdata[0];
					CFG_REF:    ref_q  <= cfg_wdata;
					CFG_GAIN:   gain_q <= cfg_wdata[7:0];
					CFG_DOUBLE: dbl_q  <= cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_mul) begin
			if (cnt_q == '0) begin
				mul_acc_q <= '0;
				mul_a_q   <= op_a;
				mul_b_q   <= op_b;
			end else begin
				mul_acc_q <= prod;
				mul_a_q   <= mul_a_q <<< 1;
				mul_b_q   <= mul_b_q >> 1;
			end
		end
		if (is_div) begin
			if (cnt_q == '0) begin
				quo_q <= op_num;
				rem_q <= '0;
				den_q <= op_den;
				neg_q <= op_neg;
			end else begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
			end
		end
		if (skip)
			g_q <= '0;
		unique case (state_q)
			ST_IDLE: if (in_valid) code_q <= ADC_BITS'(adc_code);
			ST_CHK: begin
				res_t_q  <= '0;
				res_ok_q <= 1'b0;
			end
			ST_RMUL: if (unit_done) g_q <= $signed(rnum_w[63:0]);
			ST_RDIV: if (unit_done) begin
				r_q    <= quo_nx[R_W-1:0];
				cold_q <= quo_nx < R0_Q16[sel_q];
			end
			ST_T0: if (unit_done) begin
				t_q    <= clamp_t(q_s);
				iter_q <= '0;
			end
			ST_H1, ST_G1: if (unit_done) g_q <= prod >>> 16;
			ST_H2: if (unit_done) g_q <= CB2_Q52 + (prod >>> 26);
			ST_H3: if (unit_done) g_q <= CA_Q43 + (prod >>> 25);
			ST_HS: if (unit_done) slope_q <= slope_v;
			ST_G2: if (unit_done) g_q <= CB_Q54 + (prod >>> 26);
			ST_G3: if (unit_done) g_q <= CA_Q43 + (prod >>> 27);
			ST_GP: if (unit_done) g_q <= ONE_Q32 + (prod >>> 27);
			ST_GR: if (unit_done) g_q <= $signed({36'd0, r_q}) - (prod >>> 16);
			ST_ND: if (unit_done) begin
				t_q    <= nt[31:0];
				iter_q <= iter_q + ITER_W'(1);
			end
			ST_FIN: begin
				res_ok_q <= 1'b1;
				if (tr < OUT_MIN)
					res_t_q <= OUT_MIN[TEMP_W-1:0];
				else if (tr > OUT_MAX)
					res_t_q <= OUT_MAX[TEMP_W-1:0];
				else
					res_t_q <= tr[TEMP_W-1:0];
			end
			ST_DONE: if (!out_valid_q || out_ready) begin
				temp_q     <= res_t_q;
				in_range_q <= res_ok_q;
			end
			default: ;
		endcase
	end

endmodule

[rtl/rtdc_checker.sv]
`timescale 1ns / 1ps
module rtdc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [rtdc_pkg::TEMP_W-1:0] temperature,
	input logic                         in_range
);
	import rtdc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(temperature) && $stable(in_range))
		else $error("output word changed while stalled");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> temperature == '0)
		else $error("out of span word with nonzero temperature");

	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature >= -21'sd204800 && temperature <= 21'sd870400)
		else $error("temperature beyond span");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second word while busy");

endmodule

bind rtd_code_to_temperature rtdc_checker u_rtdc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.temperature(temperature),
	.in_range(in_range)
);

[bench/rtd_code_to_temperature_tb.sv]
`timescale 1ns / 1ps
module rtd_code_to_temperature_tb;
	import rtdc_pkg::*;

	typedef struct {
		logic [CODE_W-1:0] code;
		bit                has_exp;
		logic signed [TEMP_W-1:0] temp;
		logic              inr;
	} stim_row_t;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic              inr;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CODE_W-1:0] adc_code = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [TEMP_W-1:0] temperature;
	logic in_range;
	logic cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	rtd_code_to_temperature u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .adc_code(adc_code),
		.out_valid(out_valid), .out_ready(out_ready),
		.temperature(temperature), .in_range(in_range),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the registers
	bit        sel_r = 1'b0;
	bit [15:0] ref_r = 16'd1500;
	bit [7:0]  gain_r = 8'd1;
	bit        dbl_r = 1'b1;

	reading_t pending_readings[$];
	int errors = 0;
	int mismatches = 0;
	int words_in = 0;
	int words_out = 0;
	int in_span_cnt = 0;
	bit idle_free = 1'b0;
	bit hold_rx = 1'b0;

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_deg(longint t);
		if (t < T_MIN) return T_MIN;
		if (t > T_MAX) return T_MAX;
		return t;
	endfunction

	function automatic longint poly_ohms(longint t, longint r0, bit cold);
		longint g1, g2, g3, p;
		g1 = cold ? fshr(CC_Q64 * (t - 100 * 65536), 16) : 0;
		g2 = CB_Q54 + fshr(g1 * t, 26);
		g3 = CA_Q43 + fshr(g2 * t, 27);
		p = 64'sd4294967296 + fshr(g3 * t, 27);
		return fshr(p * r0, 16);
	endfunction

	function automatic longint poly_slope(longint t, longint r0, bit cold);
		longint h1, h2, h3;
		h1 = cold ? fshr(CC_Q62 * (4 * t - 300 * 65536), 16) : 0;
		h2 = CB2_Q52 + fshr(h1 * t, 26);
		h3 = CA_Q43 + fshr(h2 * t, 25);
		return fshr(h3 * r0, 19);
	endfunction

	function automatic reading_t convert_code(logic [CODE_W-1:0] code);
		reading_t res;
		longint unsigned num, r, g, lo, hi;
		longint r0, rs, t, slope, resid, nt, d, tmp;
		bit cold;
		int e;
		res.temp = '0;
		res.inr = 1'b0;
		if (code <= 24'h800000) return res;
		g = (gain_r == 0) ? 1 : gain_r;
		e = 17 + dbl_r - 24;
		num = (longint'(code) - 64'h800000) * ref_r;
		r = num / (g << (-e));
		lo = sel_r ? 12137268 : 1213727;
		hi = sel_r ? 255905628 : 25590562;
		if (r < lo || r > hi) return res;
		r0 = sel_r ? 1000 : 100;
		rs = r;
		cold = rs < r0 * 65536;
		t = clamp_deg((rs - r0 * 65536) * 64'sd4294967296 / (r0 * 64'sd16786021));
		for (int i = 0; i < 50; i++) begin
			slope = poly_slope(t, r0, cold);
			if (slope <= 0) break;
			resid = rs - poly_ohms(t, r0, cold);
			nt = clamp_deg(t + resid * 64'sd16777216 / slope);
			d = nt - t;
			t = nt;
			if (d <= STEP_DONE && d >= -STEP_DONE) break;
		end
		tmp = fshr(t + 32, 6);
		if (tmp < OUT_MIN) tmp = OUT_MIN;
		if (tmp > OUT_MAX) tmp = OUT_MAX;
		res.temp = tmp[TEMP_W-1:0];
		res.inr = 1'b1;
		return res;
	endfunction

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SENSOR: sel_r = val[0];
			CFG_REF:    ref_r = val;
			CFG_GAIN:   gain_r = val[7:0];
			CFG_DOUBLE: dbl_r = val[0];
		endcase
	endtask

	task automatic drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (pending_readings.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (40) @(posedge clk);
	endtask

	// send one word; optional typed-in expectation
	task automatic send_code(logic [CODE_W-1:0] code, bit has_exp,
			reading_t known);
		reading_t pred;
		if (!idle_free && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (!idle_free && $urandom_range(99) < 34);
		end
		pred = convert_code(code);
		if (has_exp && (pred.temp !== known.temp || pred.inr !== known.inr)) begin
			$display("table row %h disagrees with predictor", code);
			errors++;
		end
		in_valid <= 1'b1;
		adc_code <= code;
		pending_readings.push_back(pred);
		do @(posedge clk); while (!in_ready);
		words_in++;
	endtask

	always @(posedge clk) begin
		reading_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			words_out++;
			if (pending_readings.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected word %0d", temperature);
			end else begin
				exp_r = pending_readings.pop_front();
				if (exp_r.inr) in_span_cnt++;
				if (temperature !== exp_r.temp || in_range !== exp_r.inr) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: exp temp %0d in_range %0b, got %0d %0b",
							exp_r.temp, exp_r.inr, temperature, in_range);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_rx) out_ready <= 1'b0;
		else if (idle_free) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(99) >= 34);
	end

	initial begin
		#400000000;
		$display("FAIL");
		$finish;
	end

	stim_row_t dir_rows[$];
	reading_t known;

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		dir_rows = '{
			'{24'h000000, 1, 0, 0}, '{24'h7FFFFF, 1, 0, 0}, '{24'h800000, 1, 0, 0},
			'{24'hFFFFFF, 1, 0, 0}, '{24'h800001, 1, 0, 0},
			'{24'h8111D0, 0, 0, 0}, '{24'h844444, 0, 0, 0}, '{24'h888888, 0, 0, 0},
			'{24'h8CCCCC, 0, 0, 0}, '{24'h904000, 0, 0, 0}, '{24'h84B000, 0, 0, 0}
		};
		foreach (dir_rows[i]) begin
			known.temp = dir_rows[i].temp;
			known.inr = dir_rows[i].inr;
			send_code(dir_rows[i].code, dir_rows[i].has_exp, known);
		end
		drain();
		// receiver holds off while sender keeps pushing
		hold_rx = 1'b1;
		fork
			begin
				int c;
				for (c = 0; c < 20000; c++) @(posedge clk);
				hold_rx = 1'b0;
			end
			for (int k = 0; k < 4; k++)
				send_code(CODE_W'(24'h840000 + $urandom_range(24'h40000)), 0, known);
		join
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_SENSOR, 16'd1); write_reg(CFG_REF, 16'd15000); end
				1: begin write_reg(CFG_SENSOR, 16'd0); write_reg(CFG_REF, 16'd1);
					write_reg(CFG_GAIN, 16'd128); write_reg(CFG_DOUBLE, 16'd0); end
				2: begin write_reg(CFG_REF, 16'hFFFF); write_reg(CFG_GAIN, 16'd128);
					write_reg(CFG_DOUBLE, 16'd1); end
				3: begin write_reg(CFG_REF, 16'd400); write_reg(CFG_GAIN, 16'd0); end
				4: begin write_reg(CFG_SENSOR, 16'd1); write_reg(CFG_REF, 16'd4000);
					write_reg(CFG_GAIN, 16'd2); write_reg(CFG_DOUBLE, 16'd0); end
				5: begin write_reg(CFG_SENSOR, 16'd0); write_reg(CFG_REF, 16'd1500);
					write_reg(CFG_GAIN, 16'd1); write_reg(CFG_DOUBLE, 16'd1); end
			endcase
			idle_free = (ph == 2);
			for (int k = 0; k < 48; k++) begin
				logic [CODE_W-1:0] c;
				// mostly codes above midpoint, scaled to reach the sensor span
				if ($urandom_range(9) < 2) c = CODE_W'($urandom);
				else if ($urandom_range(3) == 0)
					c = CODE_W'(24'h800000 + $urandom_range(24'h7FFFFF));
				else
					c = CODE_W'(24'h800000 + ($urandom_range(24'h7FFFFF) >> $urandom_range(8)));
				send_code(c, 0, known);
			end
			idle_free = 1'b0;
			drain();
		end
		$display("%0d words sent, %0d received, %0d within sensor span, six settings",
			words_in, words_out, in_span_cnt);
		if (errors == 0 && pending_readings.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

[files.f]
rtl/rtdc_pkg.sv
rtl/rtd_code_to_temperature.sv
rtl/rtdc_checker.sv
bench/rtd_code_to_temperature_tb.sv
